// ===== rtl/core/smdt_pkg.sv =====
package smdt_pkg;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_COEFF = 2'd1;
    localparam logic [1:0] KIND_DEPTH = 2'd2;

    localparam logic [1:0] REASON_TESTED  = 2'd0;
    localparam logic [1:0] REASON_BEHIND  = 2'd1;
    localparam logic [1:0] REASON_OUTSIDE = 2'd2;

    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH_BIAS = 2'd2;

    localparam logic signed [31:0] EMPTY_DEPTH = 32'sh7FFF_FFFF;
    localparam logic signed [32:0] ONE_Q16     = 33'sd65536;
    localparam logic [3:0]         NEIGH_TAPS  = 4'd9;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [3:0]         coeff_index;
        logic [7:0]         texel_x;
        logic [7:0]         texel_y;
        logic signed [31:0] write_value;
    } item_t;

    typedef struct packed {
        logic [8:0]  map_width;
        logic [8:0]  map_height;
        logic [16:0] depth_bias;
    } cfg_t;

    // Truncation toward zero of a Q32.32 product back to Q16.16.
    function automatic logic signed [47:0] trunc_q16(input logic signed [63:0] p);
        logic signed [63:0] adj;
        begin
            adj = p[63] ? (p + 64'sd65535) : p;
            trunc_q16 = 48'(adj >>> 16);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        begin
            if (v > 50'sd2147483647)
                sat32 = 32'sh7FFF_FFFF;
            else if (v < -50'sd2147483648)
                sat32 = 32'sh8000_0000;
            else
                sat32 = 32'(v);
        end
    endfunction

endpackage

// ===== rtl/core/smdt_ram.sv =====
module smdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[addr] <= wdata;
        rdata <= mem_reg[addr];
    end

endmodule

// ===== rtl/core/smdt_div.sv =====
module smdt_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic [30:0]        den,
    output logic               done,
    output logic signed [31:0] quot
);

    logic [47:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        neg_reg;
    logic        done_reg;

    logic [31:0] mag;
    logic [31:0] rem_sh;
    logic        ge;

    assign mag    = num[31] ? 32'(-num) : 32'(num);
    assign rem_sh = {rem_reg[30:0], dvd_reg[47]};
    assign ge     = rem_sh >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            neg_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dvd_reg  <= {mag, 16'h0000};
                rem_reg  <= '0;
                cnt_reg  <= 6'd48;
                busy_reg <= 1'b1;
                neg_reg  <= num[31];
            end
            else if (busy_reg)
            begin
                // One quotient bit per cycle, shifted in behind the dividend.
                rem_reg <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
                dvd_reg <= {dvd_reg[46:0], ge};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
            quot = (dvd_reg > 48'h0000_8000_0000) ? 32'sh8000_0000
                                                 : 32'(~dvd_reg[31:0] + 32'd1);
        else
            quot = (dvd_reg > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(dvd_reg);
    end

    assign done = done_reg;

endmodule

// ===== rtl/core/smdt_front.sv =====
module smdt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [151:0]         s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 hold,
    output logic                 q_valid,
    input  logic                 q_ready,
    output smdt_pkg::item_t      q_item
);
    import smdt_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    item_t       in_item;
    logic        push;
    logic        pop;
    logic        take;

    always_comb
    begin
        in_item.kind        = s_tuser;
        in_item.point_x     = s_tdata[31:0];
        in_item.point_y     = s_tdata[63:32];
        in_item.point_z     = s_tdata[95:64];
        in_item.coeff_index = s_tdata[99:96];
        in_item.texel_x     = s_tdata[107:100];
        in_item.texel_y     = s_tdata[115:108];
        in_item.write_value = s_tdata[147:116];
    end

    assign s_tready = (count_reg != 2'd2) && !hold;
    assign take     = s_tvalid && s_tready;
    // The unused kind is dropped here; it never reaches the back end.
    assign push     = take && (s_tuser == KIND_QUERY || s_tuser == KIND_COEFF
                               || s_tuser == KIND_DEPTH);
    assign q_valid  = count_reg != 2'd0;
    assign q_item   = slot_reg[rd_ptr_reg];
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/core/smdt_back.sv =====
module smdt_back #(
    parameter int W_MAX = 256,
    parameter int H_MAX = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  smdt_pkg::cfg_t   cfg,
    input  logic             q_valid,
    output logic             q_ready,
    input  smdt_pkg::item_t  q_item,
    output logic             clearing,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic             m_lit,
    output logic [1:0]       m_reason
);
    import smdt_pkg::*;

    localparam int DEPTH = W_MAX * H_MAX;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MUL, ST_ACC, ST_WCHK, ST_DIV, ST_DIVW,
        ST_TEX, ST_EDGE, ST_READ, ST_RESULT
    } state_t;

    state_t              state_reg;
    item_t               item_reg;
    logic signed [31:0]  coeff_reg [16];
    logic signed [31:0]  clip_reg [4];
    logic [1:0]          row_reg;
    logic [1:0]          col_reg;
    logic signed [63:0]  prod_reg;
    logic signed [49:0]  acc_reg;
    logic [1:0]          div_sel_reg;
    logic signed [31:0]  nx_reg;
    logic signed [31:0]  ny_reg;
    logic signed [31:0]  nz_reg;
    logic signed [42:0]  tpx_reg;
    logic signed [42:0]  tpy_reg;
    logic [AW-1:0]       addr_reg;
    logic [AW-1:0]       clr_reg;
    logic [3:0]          rd_cnt_reg;
    logic [1:0]          dx_reg;
    logic                rd_pend_reg;
    logic                lit_reg;
    logic                res_lit_reg;
    logic [1:0]          res_reason_reg;
    logic                out_valid_reg;
    logic                out_lit_reg;
    logic [1:0]          out_reason_reg;

    logic [3:0]          coef_idx;
    logic signed [31:0]  coef_rd;
    logic signed [31:0]  coord;
    logic signed [47:0]  term;
    logic signed [49:0]  acc_sum;
    logic signed [49:0]  row_sum;
    logic                div_done;
    logic signed [31:0]  div_quot;
    logic [8:0]          w_eff;
    logic [8:0]          h_eff;
    logic signed [25:0]  tx;
    logic signed [25:0]  ty;
    logic                outside;
    logic [AW-1:0]       base;
    logic                wr_ok;
    logic                hit;
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [31:0]         ram_wdata;
    logic [31:0]         ram_rdata;
    logic signed [33:0]  bound;

    assign coef_idx = (state_reg == ST_ACC) ? {row_reg, 2'd3} : {row_reg, col_reg};
    assign coef_rd  = coeff_reg[coef_idx];

    always_comb
    begin
        case (col_reg)
            2'd0:    coord = item_reg.point_x;
            2'd1:    coord = item_reg.point_y;
            default: coord = item_reg.point_z;
        endcase
    end

    assign term    = trunc_q16(prod_reg);
    assign acc_sum = acc_reg + 50'(term);
    assign row_sum = acc_sum + 50'(coef_rd);

    smdt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_DIV),
        .num   (clip_reg[div_sel_reg]),
        .den   (clip_reg[3][30:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign w_eff = (32'(cfg.map_width) > W_MAX) ? 9'(W_MAX) : cfg.map_width;
    assign h_eff = (32'(cfg.map_height) > H_MAX) ? 9'(H_MAX) : cfg.map_height;

    // Texel position: product over 2^17, rounded toward zero.
    assign tx = tpx_reg[42] ? 26'((tpx_reg + 43'sd131071) >>> 17) : 26'(tpx_reg >>> 17);
    assign ty = tpy_reg[42] ? 26'((tpy_reg + 43'sd131071) >>> 17) : 26'(tpy_reg >>> 17);

    assign outside = (tx < 26'sd1) || (ty < 26'sd1)
                  || (tx >= $signed({17'd0, w_eff}) - 26'sd1)
                  || (ty >= $signed({17'd0, h_eff}) - 26'sd1);

    assign base = AW'(AW'(ty - 26'sd1) * AW'(W_MAX)) + AW'(tx - 26'sd1);

    assign wr_ok = (32'(q_item.texel_x) < W_MAX) && (32'(q_item.texel_y) < H_MAX);

    assign bound = 34'(signed'(ram_rdata)) + $signed({17'd0, cfg.depth_bias});
    assign hit   = (signed'(ram_rdata) == EMPTY_DEPTH) || (34'(nz_reg) <= bound);

    assign q_ready  = state_reg == ST_IDLE;
    assign clearing = state_reg == ST_CLEAR;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = q_item.write_value;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg;
            ram_wdata = EMPTY_DEPTH;
        end
        else if (state_reg == ST_IDLE)
        begin
            ram_we   = q_valid && q_item.kind == KIND_DEPTH && wr_ok;
            ram_addr = AW'(AW'(q_item.texel_y) * AW'(W_MAX)) + AW'(q_item.texel_x);
        end
    end

    smdt_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_depth_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_item.kind == KIND_COEFF)
            coeff_reg[q_item.coeff_index] <= q_item.write_value;
        if (state_reg == ST_ACC && col_reg == 2'd2)
            clip_reg[row_reg] <= sat32(row_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            item_reg       <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            div_sel_reg    <= '0;
            nx_reg         <= '0;
            ny_reg         <= '0;
            nz_reg         <= '0;
            tpx_reg        <= '0;
            tpy_reg        <= '0;
            addr_reg       <= '0;
            clr_reg        <= '0;
            rd_cnt_reg     <= '0;
            dx_reg         <= '0;
            rd_pend_reg    <= 1'b0;
            lit_reg        <= 1'b0;
            res_lit_reg    <= 1'b0;
            res_reason_reg <= REASON_TESTED;
            out_valid_reg  <= 1'b0;
            out_lit_reg    <= 1'b0;
            out_reason_reg <= REASON_TESTED;
        end
        else
        begin
            // In the result state the output register is reloaded below instead.
            if (out_valid_reg && m_tready && state_reg != ST_RESULT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (q_valid && q_item.kind == KIND_QUERY)
                    begin
                        item_reg  <= q_item;
                        row_reg   <= '0;
                        col_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= coef_rd * coord;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (col_reg == 2'd2)
                    begin
                        acc_reg <= '0;
                        col_reg <= '0;
                        row_reg <= row_reg + 2'd1;
                        state_reg <= (row_reg == 2'd3) ? ST_WCHK : ST_MUL;
                    end
                    else
                    begin
                        acc_reg   <= acc_sum;
                        col_reg   <= col_reg + 2'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_WCHK:
                begin
                    div_sel_reg <= '0;
                    if (clip_reg[3] <= 32'sd0)
                    begin
                        res_lit_reg    <= 1'b0;
                        res_reason_reg <= REASON_BEHIND;
                        state_reg      <= ST_RESULT;
                    end
                    else
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                    state_reg <= ST_DIVW;
                ST_DIVW:
                begin
                    if (div_done)
                    begin
                        case (div_sel_reg)
                            2'd0:    nx_reg <= div_quot;
                            2'd1:    ny_reg <= div_quot;
                            default: nz_reg <= div_quot;
                        endcase
                        div_sel_reg <= div_sel_reg + 2'd1;
                        state_reg   <= (div_sel_reg == 2'd2) ? ST_TEX : ST_DIV;
                    end
                end
                ST_TEX:
                begin
                    tpx_reg   <= 43'(33'(nx_reg) + ONE_Q16) * 43'($signed({1'b0, w_eff}));
                    tpy_reg   <= 43'(33'(ny_reg) + ONE_Q16) * 43'($signed({1'b0, h_eff}));
                    state_reg <= ST_EDGE;
                end
                ST_EDGE:
                begin
                    addr_reg    <= base;
                    rd_cnt_reg  <= '0;
                    dx_reg      <= '0;
                    rd_pend_reg <= 1'b0;
                    lit_reg     <= 1'b0;
                    if (outside)
                    begin
                        res_lit_reg    <= 1'b0;
                        res_reason_reg <= REASON_OUTSIDE;
                        state_reg      <= ST_RESULT;
                    end
                    else
                        state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    // One neighborhood texel per cycle; the registered memory data returns in the next cycle.
                    rd_pend_reg <= rd_cnt_reg != NEIGH_TAPS;
                    if (rd_cnt_reg != NEIGH_TAPS)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 4'd1;
                        dx_reg     <= (dx_reg == 2'd2) ? 2'd0 : dx_reg + 2'd1;
                        addr_reg   <= (dx_reg == 2'd2) ? addr_reg + AW'(W_MAX - 2)
                                                       : addr_reg + AW'(1);
                    end
                    if (rd_pend_reg)
                        lit_reg <= lit_reg | hit;
                    if (rd_pend_reg && rd_cnt_reg == NEIGH_TAPS)
                    begin
                        res_lit_reg    <= lit_reg | hit;
                        res_reason_reg <= REASON_TESTED;
                        state_reg      <= ST_RESULT;
                    end
                end
                ST_RESULT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_lit_reg    <= res_lit_reg;
                        out_reason_reg <= res_reason_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_lit    = out_lit_reg;
    assign m_reason = out_reason_reg;

endmodule

// ===== rtl/core/shadow_map_depth_test.sv =====
// Depth write and coefficient write: no result; one beat per cycle while no query is
// being worked. Query: the matrix on one multiplier, then the three divides on the
// bit-serial divider, then the nine texels on the single depth-memory port. One query
// is worked at a time.
// After reset a clearing pass fills every depth-memory entry with the empty marker;
// no beat is accepted until it ends.
module shadow_map_depth_test #(
    parameter int MAP_WIDTH_MAX  = 256,
    parameter int MAP_HEIGHT_MAX = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, point_z, coeff_index, texel_x, texel_y, write_value, zero pad
    input  logic [151:0] s_tdata,
    // kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // lit, zero pad
    output logic [7:0]   m_tdata,
    // reject_reason
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import smdt_pkg::*;

    cfg_t   cfg_reg;
    item_t  q_item;
    logic   q_valid;
    logic   q_ready;
    logic   clearing;
    logic   lit;
    logic   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width  <= 9'd256;
            cfg_reg.map_height <= 9'd256;
            cfg_reg.depth_bias <= 17'd66;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MAP_WIDTH:  cfg_reg.map_width  <= pwdata[8:0];
                REG_MAP_HEIGHT: cfg_reg.map_height <= pwdata[8:0];
                REG_DEPTH_BIAS: cfg_reg.depth_bias <= pwdata[16:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MAP_WIDTH:  prdata = {23'd0, cfg_reg.map_width};
            REG_MAP_HEIGHT: prdata = {23'd0, cfg_reg.map_height};
            REG_DEPTH_BIAS: prdata = {15'd0, cfg_reg.depth_bias};
            default:        prdata = 32'd0;
        endcase
    end

    smdt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .hold     (clearing),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    smdt_back #(
        .W_MAX (MAP_WIDTH_MAX),
        .H_MAX (MAP_HEIGHT_MAX)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_lit    (lit),
        .m_reason (m_tuser)
    );

    assign m_tdata = {7'd0, lit};

    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_tready)
        else $error("beat accepted during depth clear");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !m_tvalid)
        else $error("result shown during depth clear");

    a_lit_only_tested: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tuser == REASON_TESTED))
        else $error("rejected query reported lit");

endmodule
